// File: hw/rtl/led_color_frame_encoder_defines.svh
// ----------------------------------------------------------------------------
// LED colour frame encoder: assertion macros
// Shared helpers for the concurrent checks of the encoder.
// ----------------------------------------------------------------------------
`ifndef LED_COLOR_FRAME_ENCODER_DEFINES_SVH
`define LED_COLOR_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LCFE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LCFE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lcfe_pkg.sv
// ----------------------------------------------------------------------------
// LED colour frame encoder package
// Constants, table address map, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package lcfe_pkg;

    // Number of LED positions along the strip.
    localparam int LED_COUNT = 64;

    // Address map of the shared table memory.
    localparam int KNOTS     = 17;
    localparam int DEC_BASE  = 0;
    localparam int RAD_BASE  = 256;
    localparam int TRIM_BASE = RAD_BASE + LED_COUNT;
    localparam int BAL_BASE  = TRIM_BASE + LED_COUNT;
    localparam int GLB_BASE  = BAL_BASE + 3;
    localparam int PWM_BASE  = GLB_BASE + 32;
    localparam int MEM_DEPTH = PWM_BASE + 3 * KNOTS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    // Arithmetic constants.
    localparam logic [14:0] Q15_MAX      = 15'h7fff;
    localparam logic [15:0] Q15_MAX16    = 16'h7fff;
    localparam logic [15:0] TRIM_MAX     = 16'd4096;
    localparam logic [34:0] LIGHT_K      = 35'd32767000000;
    localparam logic [7:0]  FRAME_BASE   = 8'he0;
    localparam logic [7:0]  MIN_PEAK_PWM = 8'd32;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MASTER_GAIN = 3'd0;
    localparam logic [2:0] CFG_FLOOR       = 3'd1;
    localparam logic [2:0] CFG_CEILING     = 3'd2;
    localparam logic [2:0] CFG_MODE        = 3'd3;
    localparam logic [2:0] CFG_TEST_LEVEL  = 3'd4;

    // Operating modes.
    localparam logic [2:0] MODE_OFF    = 3'd0;
    localparam logic [2:0] MODE_NORMAL = 3'd1;
    localparam logic [2:0] MODE_GRAY   = 3'd2;
    localparam logic [2:0] MODE_RED    = 3'd3;
    localparam logic [2:0] MODE_GREEN  = 3'd4;
    localparam logic [2:0] MODE_BLUE   = 3'd5;
    localparam logic [2:0] MODE_RADIAL = 3'd6;
    localparam logic [2:0] MODE_OFF_HI = 3'd7;

    // Table selections of a write beat.
    localparam logic [2:0] TSEL_DECODE  = 3'd0;
    localparam logic [2:0] TSEL_RADIAL  = 3'd1;
    localparam logic [2:0] TSEL_TRIM    = 3'd2;
    localparam logic [2:0] TSEL_BALANCE = 3'd3;
    localparam logic [2:0] TSEL_GLOBAL  = 3'd4;
    localparam logic [2:0] TSEL_PWM_R   = 3'd5;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RAD_MUL,
        ST_RAD_LOAD,
        ST_RAD_DONE,
        ST_T0,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_T4,
        ST_T5,
        ST_T6,
        ST_T7,
        ST_T8,
        ST_SR_START,
        ST_SR_RD,
        ST_SR_CHK,
        ST_SR_AFTER,
        ST_SR_NEXT,
        ST_FN_RD,
        ST_FN_CHK,
        ST_FN_AFTER,
        ST_NI_MUL,
        ST_NI_LOAD,
        ST_NI_RD_LAST,
        ST_NI_LAST,
        ST_NI_LO,
        ST_NI_HI,
        ST_NI_FRAC_LOAD,
        ST_NI_FRAC_DONE,
        ST_DIV_CHK,
        ST_DIV_STEP,
        ST_FIN
    } state_t;

endpackage

// File: hw/rtl/led_color_frame_encoder.sv
// ----------------------------------------------------------------------------
// LED colour frame encoder
// Turns an RGB colour for one LED position into a 32-bit LED frame.
// ----------------------------------------------------------------------------
// A table write beat is taken and the block stays ready. An encode beat keeps
// the block busy: three target light computations first, then for every
// brightness level searched and for each of the three channels at the end a
// normalise and curve inversion. The busy time is set by the single shared
// restoring divider, the shared multiplier and the table memory with its single
// read port, whose knots are read one per cycle. A finished frame waits in an
// output register, so a new beat may be taken before it is read.
module led_color_frame_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_led_index,
    input  logic [7:0]  s_red_in,
    input  logic [7:0]  s_green_in,
    input  logic [7:0]  s_blue_in,
    input  logic [2:0]  s_table_select,
    input  logic [7:0]  s_table_index,
    input  logic [15:0] s_table_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_led_frame
);
    import lcfe_pkg::*;

    // Configuration registers.
    logic [11:0] master_gain_reg;
    logic [4:0]  floor_reg;
    logic [4:0]  ceiling_reg;
    logic [2:0]  mode_reg;
    logic [7:0]  test_level_reg;

    // Sequencer.
    state_t state_reg, state_next;
    state_t div_ret_reg, div_ret_next;
    state_t ni_ret_reg, ni_ret_next;

    // Item and working registers.
    logic [7:0]       led_reg, led_next;
    logic [2:0][7:0]  src_reg, src_next;
    logic [1:0]       ch_reg, ch_next;
    logic [3:0]       k_reg, k_next;
    logic [4:0]       lvl_reg, lvl_next;
    logic [4:0]       bright_reg, bright_next;
    logic [14:0]      max_reg, max_next;
    logic [1:0]       peak_reg, peak_next;
    logic [2:0][14:0] tgt_reg, tgt_next;
    logic [2:0][7:0]  pwm_reg, pwm_next;
    logic [14:0]      g_reg, g_next;
    logic [14:0]      nt_reg, nt_next;
    logic [14:0]      tv_reg, tv_next;
    logic [14:0]      lo_reg, lo_next;
    logic [14:0]      hi_reg, hi_next;
    logic [14:0]      r_reg, r_next;
    logic [1:0]       cur_ch_reg, cur_ch_next;
    logic [7:0]       code_reg, code_next;
    logic [26:0]      a_reg, a_next;
    logic [15:0]      bal_reg, bal_next;
    logic [27:0]      chi_reg, chi_next;
    logic [42:0]      lo_p_reg, lo_p_next;
    logic [31:0]      frame_reg, frame_next;

    // Shared multiplier.
    logic [27:0] mul_x;
    logic [28:0] mul_y;
    logic        mul_en;
    logic [56:0] mul_p;
    logic [56:0] prod_reg, prod_next;

    // Shared restoring divider.
    logic [60:0] rem_reg, rem_next;
    logic [49:0] dsh_reg, dsh_next;
    logic [14:0] quo_reg, quo_next;
    logic [3:0]  dcnt_reg, dcnt_next;
    logic        div_load;
    logic [60:0] div_dvd;
    logic [34:0] div_dvs;
    logic        div_ge;

    // Output register.
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_frame_reg, m_frame_next;

    // Table memory.
    logic [15:0]       mem [MEM_DEPTH];
    logic [15:0]       mem_q;
    logic [MEM_AW-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_AW-1:0] wr_addr;
    logic [15:0]       wr_data;

    // Helpers.
    logic              s_accept;
    logic              bad_item;
    logic [14:0]       max_new;
    logic              gl_skip;
    logic [MEM_AW-1:0] curve_base;
    logic [70:0]       light_sum;
    logic [15:0]       val_sat;
    logic [1:0]        wr_pch;

    // Segment code of a curve inversion: (k * 255 + frac + 8) / 16.
    function automatic logic [7:0] seg_code(input logic [3:0] k, input logic [7:0] frac);
        logic [12:0] s;
        s = {1'b0, k, 8'd0} - 13'(k) + 13'(frac) + 13'd8;
        return s[11:4];
    endfunction

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_led_frame = m_frame_reg;

    assign bad_item = ({1'b0, s_led_index} >= 9'(LED_COUNT)) || (mode_reg == MODE_OFF)
                      || (mode_reg == MODE_OFF_HI);
    assign mul_p      = 57'(mul_x) * 57'(mul_y);
    assign div_ge     = (rem_reg >= {11'd0, dsh_reg});
    assign max_new    = ((ch_reg == 2'd0) || (quo_reg > max_reg)) ? quo_reg : max_reg;
    assign gl_skip    = (mem_q[14:0] == 15'd0) || (mem_q[14:0] < max_reg);
    assign curve_base = MEM_AW'(PWM_BASE) + MEM_AW'({cur_ch_reg, 4'b0000})
                        + MEM_AW'(cur_ch_reg);
    assign light_sum  = {prod_reg[42:0], 28'd0} + {28'd0, lo_p_reg};
    assign val_sat    = (s_table_value > Q15_MAX16) ? Q15_MAX16 : s_table_value;
    assign wr_pch     = 2'(s_table_select - TSEL_PWM_R);

    // Table write decode: out-of-range indexes are dropped.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = val_sat;
        case (s_table_select)
            TSEL_DECODE: begin
                wr_en   = 1'b1;
                wr_addr = MEM_AW'(DEC_BASE) + MEM_AW'(s_table_index);
            end
            TSEL_RADIAL: begin
                wr_en   = ({1'b0, s_table_index} < 9'(LED_COUNT));
                wr_addr = MEM_AW'(RAD_BASE) + MEM_AW'(s_table_index);
            end
            TSEL_TRIM: begin
                wr_en   = ({1'b0, s_table_index} < 9'(LED_COUNT));
                wr_addr = MEM_AW'(TRIM_BASE) + MEM_AW'(s_table_index);
                wr_data = (s_table_value > TRIM_MAX) ? TRIM_MAX : s_table_value;
            end
            TSEL_BALANCE: begin
                wr_en   = (s_table_index < 8'd3);
                wr_addr = MEM_AW'(BAL_BASE) + MEM_AW'(s_table_index);
                wr_data = s_table_value;
            end
            TSEL_GLOBAL: begin
                wr_en   = (s_table_index < 8'd32);
                wr_addr = MEM_AW'(GLB_BASE) + MEM_AW'(s_table_index);
            end
            default: begin
                wr_en   = (s_table_index < 8'(KNOTS));
                wr_addr = MEM_AW'(PWM_BASE) + MEM_AW'({wr_pch, 4'b0000}) + MEM_AW'(wr_pch)
                          + MEM_AW'(s_table_index);
            end
        endcase
        wr_en = wr_en && s_accept && s_func;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q <= mem[rd_addr];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_gain_reg <= 12'd1000;
            floor_reg       <= 5'd1;
            ceiling_reg     <= 5'd31;
            mode_reg        <= MODE_OFF;
            test_level_reg  <= 8'd255;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MASTER_GAIN: master_gain_reg <= cfg_data;
                CFG_FLOOR:       floor_reg       <= cfg_data[4:0];
                CFG_CEILING:     ceiling_reg     <= cfg_data[4:0];
                CFG_MODE:        mode_reg        <= cfg_data[2:0];
                CFG_TEST_LEVEL:  test_level_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && !s_func) begin
                    if (bad_item) begin
                        state_next = ST_FIN;
                    end else if (mode_reg == MODE_RADIAL) begin
                        state_next = ST_RAD_MUL;
                    end else begin
                        state_next = ST_T0;
                    end
                end
            end
            ST_RAD_MUL:  state_next = ST_RAD_LOAD;
            ST_RAD_LOAD: state_next = ST_DIV_CHK;
            ST_RAD_DONE: state_next = ST_T0;
            ST_T0:       state_next = ST_T1;
            ST_T1:       state_next = ST_T2;
            ST_T2:       state_next = ST_T3;
            ST_T3:       state_next = ST_T4;
            ST_T4:       state_next = ST_T5;
            ST_T5:       state_next = ST_T6;
            ST_T6:       state_next = ST_T7;
            ST_T7:       state_next = ST_DIV_CHK;
            ST_T8: begin
                if (ch_reg != 2'd2) begin
                    state_next = ST_T0;
                end else if (max_new == 15'd0) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_SR_START;
                end
            end
            ST_SR_START: state_next = (floor_reg > ceiling_reg) ? ST_FN_RD : ST_SR_RD;
            ST_SR_RD:    state_next = ST_SR_CHK;
            ST_SR_CHK:   state_next = gl_skip ? ST_SR_NEXT : ST_NI_MUL;
            ST_SR_AFTER: state_next = (code_reg >= MIN_PEAK_PWM) ? ST_FN_RD : ST_SR_NEXT;
            ST_SR_NEXT:  state_next = (lvl_reg == floor_reg) ? ST_FN_RD : ST_SR_RD;
            ST_FN_RD:    state_next = ST_FN_CHK;
            ST_FN_CHK:   state_next = (mem_q[14:0] == 15'd0) ? ST_FIN : ST_NI_MUL;
            ST_FN_AFTER: state_next = (ch_reg == 2'd2) ? ST_FIN : ST_NI_MUL;
            ST_NI_MUL:   state_next = ST_NI_LOAD;
            ST_NI_LOAD:  state_next = ST_DIV_CHK;
            ST_NI_RD_LAST: state_next = ST_NI_LAST;
            ST_NI_LAST: begin
                if ((tv_reg == 15'd0) || (mem_q[14:0] == 15'd0) || (tv_reg >= mem_q[14:0])) begin
                    state_next = ni_ret_reg;
                end else begin
                    state_next = ST_NI_LO;
                end
            end
            ST_NI_LO: state_next = ST_NI_HI;
            ST_NI_HI: begin
                if (tv_reg <= mem_q[14:0]) begin
                    if ((mem_q[14:0] > lo_reg) && (tv_reg >= lo_reg)) begin
                        state_next = ST_NI_FRAC_LOAD;
                    end else begin
                        state_next = ni_ret_reg;
                    end
                end
            end
            ST_NI_FRAC_LOAD: state_next = ST_DIV_CHK;
            ST_NI_FRAC_DONE: state_next = ni_ret_reg;
            ST_DIV_CHK:  state_next = div_ge ? div_ret_reg : ST_DIV_STEP;
            ST_DIV_STEP: state_next = (dcnt_reg == 4'd0) ? div_ret_reg : ST_DIV_STEP;
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs per state.
    always_comb begin
        div_ret_next = div_ret_reg;
        ni_ret_next  = ni_ret_reg;
        led_next     = led_reg;
        src_next     = src_reg;
        ch_next      = ch_reg;
        k_next       = k_reg;
        lvl_next     = lvl_reg;
        bright_next  = bright_reg;
        max_next     = max_reg;
        peak_next    = peak_reg;
        tgt_next     = tgt_reg;
        pwm_next     = pwm_reg;
        g_next       = g_reg;
        nt_next      = nt_reg;
        tv_next      = tv_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        r_next       = r_reg;
        cur_ch_next  = cur_ch_reg;
        code_next    = code_reg;
        a_next       = a_reg;
        bal_next     = bal_reg;
        chi_next     = chi_reg;
        lo_p_next    = lo_p_reg;
        frame_next   = frame_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        mul_x        = '0;
        mul_y        = '0;
        mul_en       = 1'b0;
        div_load     = 1'b0;
        div_dvd      = '0;
        div_dvs      = '0;
        rd_addr      = '0;
        m_valid_next = m_valid_reg && !m_ready;
        m_frame_next = m_frame_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && !s_func) begin
                    led_next   = s_led_index;
                    ch_next    = 2'd0;
                    frame_next = 32'd0;
                    case (mode_reg)
                        MODE_GRAY:  src_next = {test_level_reg, test_level_reg, test_level_reg};
                        MODE_RED:   src_next = {8'd0, 8'd0, test_level_reg};
                        MODE_GREEN: src_next = {8'd0, test_level_reg, 8'd0};
                        MODE_BLUE:  src_next = {test_level_reg, 8'd0, 8'd0};
                        default:    src_next = {s_blue_in, s_green_in, s_red_in};
                    endcase
                end
            end
            // Radial test level: test_level * led / (LED_COUNT - 1).
            ST_RAD_MUL: begin
                mul_x  = 28'(test_level_reg);
                mul_y  = 29'(led_reg);
                mul_en = 1'b1;
            end
            ST_RAD_LOAD: begin
                div_load     = 1'b1;
                div_dvd      = 61'(prod_reg[15:0]);
                div_dvs      = 35'(LED_COUNT - 1);
                div_ret_next = ST_RAD_DONE;
            end
            ST_RAD_DONE: begin
                src_next = {quo_reg[7:0], quo_reg[7:0], quo_reg[7:0]};
            end
            // Target light of one channel, built from four table reads.
            ST_T0: begin
                rd_addr = MEM_AW'(DEC_BASE) + MEM_AW'(src_reg[ch_reg]);
            end
            ST_T1: begin
                mul_x   = 28'(mem_q[14:0]);
                mul_y   = 29'(master_gain_reg);
                mul_en  = 1'b1;
                rd_addr = MEM_AW'(BAL_BASE) + MEM_AW'(ch_reg);
            end
            ST_T2: begin
                a_next   = prod_reg[26:0];
                bal_next = mem_q;
                rd_addr  = MEM_AW'(TRIM_BASE) + MEM_AW'(led_reg);
            end
            ST_T3: begin
                mul_x   = 28'(bal_reg);
                mul_y   = 29'(mem_q[12:0]);
                mul_en  = 1'b1;
                rd_addr = MEM_AW'(RAD_BASE) + MEM_AW'(led_reg);
            end
            ST_T4: begin
                mul_x  = 28'(a_reg);
                mul_y  = prod_reg[28:0];
                mul_en = 1'b1;
                r_next = mem_q[14:0];
            end
            // The 56-bit product is split into two halves, each multiplied by the radial entry.
            ST_T5: begin
                mul_x    = prod_reg[27:0];
                mul_y    = 29'(r_reg);
                mul_en   = 1'b1;
                chi_next = prod_reg[55:28];
            end
            ST_T6: begin
                lo_p_next = prod_reg[42:0];
                mul_x     = chi_reg;
                mul_y     = 29'(r_reg);
                mul_en    = 1'b1;
            end
            ST_T7: begin
                div_load     = 1'b1;
                div_dvd      = light_sum[70:10];
                div_dvs      = LIGHT_K;
                div_ret_next = ST_T8;
            end
            ST_T8: begin
                tgt_next[ch_reg] = quo_reg;
                max_next         = max_new;
                if ((ch_reg == 2'd0) || (quo_reg >= max_reg)) begin
                    peak_next = ch_reg;
                end
                if (ch_reg != 2'd2) begin
                    ch_next = ch_reg + 2'd1;
                end else if (max_new == 15'd0) begin
                    frame_next = {24'd0, FRAME_BASE};
                end
            end
            // Brightness search from the ceiling downwards.
            ST_SR_START: begin
                bright_next = ceiling_reg;
                lvl_next    = ceiling_reg;
            end
            ST_SR_RD: begin
                rd_addr = MEM_AW'(GLB_BASE) + MEM_AW'(lvl_reg);
            end
            ST_SR_CHK: begin
                if (!gl_skip) begin
                    bright_next = lvl_reg;
                    g_next      = mem_q[14:0];
                    nt_next     = max_reg;
                    cur_ch_next = peak_reg;
                    ni_ret_next = ST_SR_AFTER;
                end
            end
            ST_SR_AFTER: ;
            ST_SR_NEXT: begin
                if (lvl_reg != floor_reg) begin
                    lvl_next = lvl_reg - 5'd1;
                end
            end
            // Final codes of all three channels at the chosen level.
            ST_FN_RD: begin
                rd_addr = MEM_AW'(GLB_BASE) + MEM_AW'(bright_reg);
            end
            ST_FN_CHK: begin
                if (mem_q[14:0] == 15'd0) begin
                    frame_next = {24'd0, FRAME_BASE};
                end else begin
                    g_next      = mem_q[14:0];
                    ch_next     = 2'd0;
                    nt_next     = tgt_reg[0];
                    cur_ch_next = 2'd0;
                    ni_ret_next = ST_FN_AFTER;
                end
            end
            ST_FN_AFTER: begin
                pwm_next[ch_reg] = code_reg;
                if (ch_reg == 2'd2) begin
                    frame_next = {pwm_reg[0], pwm_reg[1], code_reg, FRAME_BASE[7:5], bright_reg};
                end else begin
                    ch_next     = ch_reg + 2'd1;
                    nt_next     = tgt_reg[ch_reg + 2'd1];
                    cur_ch_next = ch_reg + 2'd1;
                end
            end
            // Normalise: (t * 32767 + g / 2) / g, saturated by the divider.
            ST_NI_MUL: begin
                mul_x  = 28'(nt_reg);
                mul_y  = 29'(Q15_MAX);
                mul_en = 1'b1;
            end
            ST_NI_LOAD: begin
                div_load     = 1'b1;
                div_dvd      = 61'(prod_reg[29:0]) + 61'(g_reg[14:1]);
                div_dvs      = 35'(g_reg);
                div_ret_next = ST_NI_RD_LAST;
            end
            // Curve inversion: last knot first, then a walk over the segments.
            ST_NI_RD_LAST: begin
                tv_next = quo_reg;
                rd_addr = curve_base + MEM_AW'(KNOTS - 1);
            end
            ST_NI_LAST: begin
                if ((tv_reg == 15'd0) || (mem_q[14:0] == 15'd0)) begin
                    code_next = 8'd0;
                end else if (tv_reg >= mem_q[14:0]) begin
                    code_next = 8'd255;
                end else begin
                    rd_addr = curve_base;
                    k_next  = 4'd0;
                end
            end
            ST_NI_LO: begin
                lo_next = mem_q[14:0];
                rd_addr = curve_base + MEM_AW'(k_reg) + MEM_AW'(1);
            end
            ST_NI_HI: begin
                hi_next = mem_q[14:0];
                if (tv_reg <= mem_q[14:0]) begin
                    if ((mem_q[14:0] > lo_reg) && (tv_reg >= lo_reg)) begin
                        mul_x  = 28'(tv_reg - lo_reg);
                        mul_y  = 29'd255;
                        mul_en = 1'b1;
                    end else begin
                        code_next = seg_code(k_reg, 8'd0);
                    end
                end else begin
                    lo_next = mem_q[14:0];
                    k_next  = k_reg + 4'd1;
                    rd_addr = curve_base + MEM_AW'(k_reg) + MEM_AW'(2);
                end
            end
            ST_NI_FRAC_LOAD: begin
                div_load     = 1'b1;
                div_dvd      = 61'(prod_reg[22:0]);
                div_dvs      = 35'(hi_reg - lo_reg);
                div_ret_next = ST_NI_FRAC_DONE;
            end
            ST_NI_FRAC_DONE: begin
                code_next = seg_code(k_reg, quo_reg[7:0]);
            end
            // Divider: overflow check, then one quotient bit per cycle.
            ST_DIV_CHK: begin
                if (div_ge) begin
                    quo_next = Q15_MAX;
                end else begin
                    dsh_next  = dsh_reg >> 1;
                    dcnt_next = 4'd14;
                end
            end
            ST_DIV_STEP: begin
                if (div_ge) begin
                    rem_next = rem_reg - {11'd0, dsh_reg};
                end
                quo_next  = {quo_reg[13:0], div_ge};
                dsh_next  = dsh_reg >> 1;
                dcnt_next = dcnt_reg - 4'd1;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_frame_next = frame_reg;
                end
            end
            default: ;
        endcase

        // Divider start shared by all callers.
        if (div_load) begin
            rem_next = div_dvd;
            dsh_next = {div_dvs, 15'd0};
            quo_next = 15'd0;
        end
    end

    assign prod_next = mul_en ? mul_p : prod_reg;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_ret_reg <= ST_IDLE;
            ni_ret_reg  <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_ret_reg <= div_ret_next;
            ni_ret_reg  <= ni_ret_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        led_reg     <= led_next;
        src_reg     <= src_next;
        ch_reg      <= ch_next;
        k_reg       <= k_next;
        lvl_reg     <= lvl_next;
        bright_reg  <= bright_next;
        max_reg     <= max_next;
        peak_reg    <= peak_next;
        tgt_reg     <= tgt_next;
        pwm_reg     <= pwm_next;
        g_reg       <= g_next;
        nt_reg      <= nt_next;
        tv_reg      <= tv_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        r_reg       <= r_next;
        cur_ch_reg  <= cur_ch_next;
        code_reg    <= code_next;
        a_reg       <= a_next;
        bal_reg     <= bal_next;
        chi_reg     <= chi_next;
        lo_p_reg    <= lo_p_next;
        frame_reg   <= frame_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        m_frame_reg <= m_frame_next;
    end

endmodule

// File: hw/rtl/lcfe_checker.sv
// ----------------------------------------------------------------------------
// LED colour frame encoder checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_color_frame_encoder_defines.svh"

module lcfe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_wr_en,
    input logic [2:0]  cfg_index,
    input logic [11:0] cfg_data,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_func,
    input logic [7:0]  s_led_index,
    input logic [7:0]  s_red_in,
    input logic [7:0]  s_green_in,
    input logic [7:0]  s_blue_in,
    input logic [2:0]  s_table_select,
    input logic [7:0]  s_table_index,
    input logic [15:0] s_table_value,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_led_frame
);

    // A stalled result beat stays offered.
    `LCFE_ASSERT_NXT(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready, m_valid, "result beat dropped while stalled")

    // A stalled result beat keeps its frame.
    `LCFE_ASSERT_NXT(a_m_frame_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_led_frame), "result frame changed while stalled")

    // Every frame is either zero or carries the frame marker bits.
    `LCFE_ASSERT_IMP(a_frame_form, aclk, aresetn, m_valid, (m_led_frame == 32'd0) || (m_led_frame[7:5] == 3'b111), "malformed LED frame")

    // An accepted encode beat makes the block busy in the next cycle.
    `LCFE_ASSERT_NXT(a_busy_after_encode, aclk, aresetn, s_valid && s_ready && !s_func, !s_ready, "ready after an encode beat")

endmodule

bind led_color_frame_encoder lcfe_checker u_lcfe_checker (.*);

// File: sim/tb_led_color_frame_encoder.sv
// ----------------------------------------------------------------------------
// Testbench for the LED colour frame encoder
// Loads every table, then runs directed beats over the special cases and
// random beats under several register settings and idling patterns. A
// scoreboard predicts each frame and compares it with the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_led_color_frame_encoder;
    import lcfe_pkg::*;

    // Function codes of an input beat and the remaining curve selections.
    localparam logic       FUNC_ENCODE = 1'b0;
    localparam logic       FUNC_WRITE  = 1'b1;
    localparam logic [2:0] TSEL_PWM_G  = 3'd6;
    localparam logic [2:0] TSEL_PWM_B  = 3'd7;

    // Idling patterns.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam logic [127:0] LIGHT_DIV = 128'd1000 * 128'd1000 * 128'd1024 * 128'd32767;

    typedef struct {
        logic        func;
        logic [7:0]  led_index;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [2:0]  table_select;
        logic [7:0]  table_index;
        logic [15:0] table_value;
    } beat_t;

    // Frame predictor with its own copy of the tables and registers.
    class frame_scoreboard;
        logic [15:0] dec_tab[256];
        logic [15:0] rad_tab[LED_COUNT];
        logic [15:0] trim_tab[LED_COUNT];
        logic [15:0] bal_tab[3];
        logic [15:0] glb_tab[32];
        logic [15:0] pwm_tab[3 * KNOTS];
        logic [11:0] gain;
        logic [4:0]  lvl_floor;
        logic [4:0]  lvl_ceiling;
        logic [2:0]  op_mode;
        logic [7:0]  test_lvl;
        logic [31:0] frames_due[$];
        int          errors;

        function new();
            foreach (dec_tab[i]) dec_tab[i] = '0;
            foreach (rad_tab[i]) rad_tab[i] = '0;
            foreach (trim_tab[i]) trim_tab[i] = '0;
            foreach (bal_tab[i]) bal_tab[i] = '0;
            foreach (glb_tab[i]) glb_tab[i] = '0;
            foreach (pwm_tab[i]) pwm_tab[i] = '0;
            gain = 12'd1000;
            lvl_floor = 5'd1;
            lvl_ceiling = 5'd31;
            op_mode = MODE_OFF;
            test_lvl = 8'd255;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [11:0] val);
            case (idx)
                CFG_MASTER_GAIN: gain = val;
                CFG_FLOOR:       lvl_floor = val[4:0];
                CFG_CEILING:     lvl_ceiling = val[4:0];
                CFG_MODE:        op_mode = val[2:0];
                CFG_TEST_LEVEL:  test_lvl = val[7:0];
                default: ;
            endcase
        endfunction

        function int unsigned invert_curve(int unsigned base, int unsigned target);
            int unsigned last, lo, hi, frac;
            last = pwm_tab[base + KNOTS - 1];
            if (target == 0 || last == 0) return 0;
            if (target >= last) return 255;
            for (int k = 0; k < KNOTS - 1; k++) begin
                lo = pwm_tab[base + k];
                hi = pwm_tab[base + k + 1];
                if (target <= hi) begin
                    frac = 0;
                    if (hi > lo && target >= lo) frac = (target - lo) * 255 / (hi - lo);
                    return (k * 255 + frac + 8) / 16;
                end
            end
            return 255;
        endfunction

        function int unsigned light(int unsigned led, int unsigned ch, int unsigned src);
            logic [127:0] prod;
            prod = 128'(dec_tab[src & 255]) * 128'(gain) * 128'(bal_tab[ch])
                 * 128'(trim_tab[led]) * 128'(rad_tab[led]);
            prod = prod / LIGHT_DIV;
            return (prod > 128'(Q15_MAX)) ? 32767 : int'(prod);
        endfunction

        function int unsigned scale_to(int unsigned t, int unsigned g);
            int unsigned n;
            n = (t * 32767 + g / 2) / g;
            return (n > 32767) ? 32767 : n;
        endfunction

        function logic [31:0] frame_of(beat_t b);
            int unsigned src[3], tgt[3], pwm[3];
            int unsigned led, lvl, peak_ch, maximum, bright, g, gl;
            led = b.led_index;
            if (led >= LED_COUNT || op_mode == MODE_OFF || op_mode == MODE_OFF_HI) return 32'd0;
            src[0] = b.red_in; src[1] = b.green_in; src[2] = b.blue_in;
            lvl = test_lvl;
            case (op_mode)
                MODE_GRAY:  begin src[0] = lvl; src[1] = lvl; src[2] = lvl; end
                MODE_RED:   begin src[0] = lvl; src[1] = 0; src[2] = 0; end
                MODE_GREEN: begin src[0] = 0; src[1] = lvl; src[2] = 0; end
                MODE_BLUE:  begin src[0] = 0; src[1] = 0; src[2] = lvl; end
                MODE_RADIAL: begin
                    lvl = lvl * led / (LED_COUNT - 1);
                    src[0] = lvl; src[1] = lvl; src[2] = lvl;
                end
                default: ;
            endcase
            maximum = 0;
            peak_ch = 0;
            for (int ch = 0; ch < 3; ch++) begin
                tgt[ch] = light(led, ch, src[ch]);
                if (tgt[ch] > maximum) maximum = tgt[ch];
                if (tgt[ch] >= tgt[peak_ch]) peak_ch = ch;
            end
            if (maximum == 0) return 32'(FRAME_BASE);
            // Search from the ceiling down for a level that lifts the peak channel.
            bright = lvl_ceiling;
            for (int level = lvl_ceiling; level >= int'(lvl_floor); level--) begin
                gl = glb_tab[level & 31];
                if (gl == 0 || gl < maximum) continue;
                bright = level;
                if (invert_curve(peak_ch * KNOTS, scale_to(maximum, gl)) >= MIN_PEAK_PWM) break;
            end
            g = glb_tab[bright & 31];
            if (g == 0) return 32'(FRAME_BASE);
            for (int ch = 0; ch < 3; ch++) pwm[ch] = invert_curve(ch * KNOTS, scale_to(tgt[ch], g));
            return (32'(FRAME_BASE) | 32'(bright)) | (pwm[2] << 8) | (pwm[1] << 16)
                 | (pwm[0] << 24);
        endfunction

        function void note_beat(beat_t b);
            int unsigned idx, val, q;
            if (b.func == FUNC_WRITE) begin
                idx = b.table_index;
                val = b.table_value;
                q = (val > 32767) ? 32767 : val;
                case (b.table_select)
                    TSEL_DECODE:  dec_tab[idx] = q;
                    TSEL_RADIAL:  if (idx < LED_COUNT) rad_tab[idx] = q;
                    TSEL_TRIM:    if (idx < LED_COUNT) trim_tab[idx] = (val > 4096) ? 4096 : val;
                    TSEL_BALANCE: if (idx < 3) bal_tab[idx] = val;
                    TSEL_GLOBAL:  if (idx < 32) glb_tab[idx] = q;
                    default: if (idx < KNOTS) pwm_tab[(b.table_select - TSEL_PWM_R) * KNOTS + idx] = q;
                endcase
            end else begin
                frames_due.push_back(frame_of(b));
            end
        endfunction

        function void check_frame(logic [31:0] frame);
            logic [31:0] want;
            if (frames_due.size() == 0) begin
                $error("led_frame expected none actual %h", frame);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (frame !== want) begin
                $error("led_frame expected %h actual %h", want, frame);
                errors++;
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [7:0]  s_led_index;
    logic [7:0]  s_red_in;
    logic [7:0]  s_green_in;
    logic [7:0]  s_blue_in;
    logic [2:0]  s_table_select;
    logic [7:0]  s_table_index;
    logic [15:0] s_table_value;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_led_frame;

    frame_scoreboard sb;
    int idle_mode;
    bit hold_req;
    int quiet_cycles;

    led_color_frame_encoder u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_led_index(s_led_index), .s_red_in(s_red_in), .s_green_in(s_green_in),
        .s_blue_in(s_blue_in), .s_table_select(s_table_select),
        .s_table_index(s_table_index), .s_table_value(s_table_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_led_frame(m_led_frame)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Monitors: note accepted input beats and check accepted frames.
    always @(posedge aclk) begin
        beat_t b;
        if (aresetn && s_valid && s_ready) begin
            b.func = s_func; b.led_index = s_led_index;
            b.red_in = s_red_in; b.green_in = s_green_in; b.blue_in = s_blue_in;
            b.table_select = s_table_select; b.table_index = s_table_index;
            b.table_value = s_table_value;
            sb.note_beat(b);
        end
        if (aresetn && m_valid && m_ready) sb.check_frame(m_led_frame);
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_led_color_frame_encoder: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (idle_mode == IDLE_RECV) m_ready = ($urandom_range(99) >= 76);
            else if (idle_mode == IDLE_BOTH) m_ready = ($urandom_range(99) >= 11);
            else m_ready = 1'b1;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [11:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Offers one beat, with random gaps before it, and returns once it is taken.
    task automatic send_beat(beat_t b);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 76 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_func = b.func; s_led_index = b.led_index;
        s_red_in = b.red_in; s_green_in = b.green_in; s_blue_in = b.blue_in;
        s_table_select = b.table_select; s_table_index = b.table_index;
        s_table_value = b.table_value;
        s_valid = 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Lowers valid and waits until every frame has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    task automatic send_write(logic [2:0] sel, logic [7:0] idx, logic [15:0] val);
        beat_t b;
        b.func = FUNC_WRITE; b.led_index = $urandom; b.red_in = $urandom;
        b.green_in = $urandom; b.blue_in = $urandom;
        b.table_select = sel; b.table_index = idx; b.table_value = val;
        send_beat(b);
    endtask

    task automatic send_pixel(logic [7:0] led, logic [7:0] r, logic [7:0] g, logic [7:0] bl);
        beat_t b;
        b.func = FUNC_ENCODE; b.led_index = led; b.red_in = r; b.green_in = g;
        b.blue_in = bl; b.table_select = $urandom; b.table_index = $urandom;
        b.table_value = $urandom;
        send_beat(b);
    endtask

    // A realistic value for an entry, so that most frames land mid-range.
    function automatic logic [15:0] sane_value(logic [2:0] sel, int idx);
        case (sel)
            TSEL_DECODE:  return (idx * idx * 32767) / (255 * 255);
            TSEL_RADIAL:  return $urandom_range(32767, 20000);
            TSEL_TRIM:    return $urandom_range(1200, 800);
            TSEL_BALANCE: return $urandom_range(1100, 900);
            TSEL_GLOBAL:  return ((idx + 1) * 32767) / 32;
            default:      return (idx >= KNOTS - 1) ? 16'd32767
                               : 16'((idx * idx * 32767) / 256 + $urandom_range(40));
        endcase
    endfunction

    task automatic load_tables();
        for (int i = 0; i < 256; i++) send_write(TSEL_DECODE, i, sane_value(TSEL_DECODE, i));
        for (int i = 0; i < LED_COUNT; i++) begin
            send_write(TSEL_RADIAL, i, sane_value(TSEL_RADIAL, i));
            send_write(TSEL_TRIM, i, sane_value(TSEL_TRIM, i));
        end
        for (int i = 0; i < 3; i++) send_write(TSEL_BALANCE, i, sane_value(TSEL_BALANCE, i));
        for (int i = 0; i < 32; i++) send_write(TSEL_GLOBAL, i, sane_value(TSEL_GLOBAL, i));
        for (int s = TSEL_PWM_R; s <= TSEL_PWM_B; s++)
            for (int k = 0; k < KNOTS; k++) send_write(s, k, sane_value(s, k));
    endtask

    task automatic random_beat();
        logic [2:0] sel;
        int idx;
        if ($urandom_range(99) < 55) begin
            send_pixel(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(LED_COUNT - 1)),
                       $urandom, $urandom, $urandom);
        end else begin
            sel = $urandom;
            idx = ($urandom_range(9) == 0) ? $urandom_range(255)
                : (sel == TSEL_BALANCE) ? $urandom_range(2)
                : (sel == TSEL_GLOBAL) ? $urandom_range(31)
                : (sel >= TSEL_PWM_R) ? $urandom_range(KNOTS - 1)
                : (sel == TSEL_DECODE) ? $urandom_range(255) : $urandom_range(LED_COUNT - 1);
            send_write(sel, idx, ($urandom_range(7) == 0) ? 16'($urandom) : sane_value(sel, idx));
        end
    endtask

    initial begin
        logic [11:0] gain_set[8]  = '{12'd1000, 12'd4000, 12'd2500, 12'd0,
                                      12'd1000, 12'd4095, 12'd700, 12'd1000};
        logic [4:0]  floor_set[8] = '{5'd1, 5'd0, 5'd31, 5'd0, 5'd5, 5'd0, 5'd0, 5'd3};
        logic [4:0]  ceil_set[8]  = '{5'd31, 5'd31, 5'd0, 5'd31, 5'd20, 5'd31, 5'd31, 5'd31};
        logic [2:0]  mode_set[8]  = '{MODE_NORMAL, MODE_NORMAL, MODE_NORMAL, MODE_GRAY,
                                      MODE_RADIAL, MODE_NORMAL, MODE_BLUE, MODE_NORMAL};
        logic [7:0]  level_set[8] = '{8'd255, 8'd0, 8'd128, 8'd200, 8'd255, 8'd77, 8'd255, 8'd1};

        sb = new();
        idle_mode = IDLE_NONE;
        hold_req = 1'b0;
        quiet_cycles = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_func = FUNC_ENCODE; s_led_index = '0;
        s_red_in = '0; s_green_in = '0; s_blue_in = '0;
        s_table_select = '0; s_table_index = '0; s_table_value = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        load_tables();

        // Directed: disabled modes and a bad LED index.
        send_pixel(8'd5, 8'd200, 8'd100, 8'd50);
        drain();
        cfg_write(CFG_MODE, MODE_OFF_HI);
        send_pixel(8'd5, 8'd200, 8'd100, 8'd50);
        drain();
        cfg_write(CFG_MODE, MODE_NORMAL);
        send_pixel(8'd64, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        // All dark, full white and an ordinary colour.
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd63, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd10, 8'd30, 8'd140, 8'd90);
        drain();
        // Each test pattern; the radial pattern at both ends of the strip.
        for (int m = MODE_GRAY; m <= MODE_RADIAL; m++) begin
            cfg_write(CFG_MODE, m);
            send_pixel(8'd63, 8'd1, 8'd2, 8'd3);
            drain();
        end
        send_pixel(8'd0, 8'd1, 8'd2, 8'd3);
        drain();
        // Floor above the ceiling.
        cfg_write(CFG_MODE, MODE_NORMAL);
        cfg_write(CFG_FLOOR, 5'd31);
        cfg_write(CFG_CEILING, 5'd0);
        send_pixel(8'd20, 8'd90, 8'd60, 8'd30);
        drain();
        // Zero global entry at the only searched level.
        cfg_write(CFG_FLOOR, 5'd7);
        cfg_write(CFG_CEILING, 5'd7);
        send_write(TSEL_GLOBAL, 8'd7, 16'd0);
        send_pixel(8'd20, 8'd90, 8'd60, 8'd30);
        send_write(TSEL_GLOBAL, 8'd7, sane_value(TSEL_GLOBAL, 7));
        // A blue curve whose last knot is zero.
        send_write(TSEL_PWM_B, 8'd16, 16'd0);
        send_pixel(8'd20, 8'd90, 8'd60, 8'd30);
        send_write(TSEL_PWM_B, 8'd16, 16'd32767);
        // Saturating and out-of-range table writes.
        send_write(TSEL_TRIM, 8'd3, 16'hffff);
        send_write(TSEL_TRIM, 8'd200, 16'd1000);
        send_write(TSEL_DECODE, 8'd200, 16'hffff);
        send_write(TSEL_BALANCE, 8'd1, 16'hffff);
        send_pixel(8'd3, 8'd200, 8'd200, 8'd200);
        drain();

        // Random phases, each under its own settings and one of the idling patterns.
        for (int p = 0; p < 8; p++) begin
            cfg_write(CFG_MASTER_GAIN, (p == 5) ? 12'($urandom) : gain_set[p]);
            cfg_write(CFG_FLOOR, floor_set[p]);
            cfg_write(CFG_CEILING, ceil_set[p]);
            cfg_write(CFG_MODE, mode_set[p]);
            cfg_write(CFG_TEST_LEVEL, level_set[p]);
            idle_mode = p % 4;
            if (p == 0) hold_req = 1'b1;
            repeat (125) random_beat();
            drain();
        end

        repeat (200) @(negedge aclk);
        if (sb.pending() != 0) begin
            $error("led_frame expected %0d more frames actual none", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb_led_color_frame_encoder: clean");
        end else begin
            $display("tb_led_color_frame_encoder: errors");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/lcfe_pkg.sv
hw/rtl/led_color_frame_encoder.sv
hw/rtl/lcfe_checker.sv
sim/tb_led_color_frame_encoder.sv
